// File: hdl/tkpl_pkg.sv
`default_nettype none

package tkpl_pkg;

  // Keypad geometry in panel pixels. Every key rectangle is inclusive on all
  // four edges: its right edge lies at left + KEY_W and its bottom at top + KEY_H.
  localparam int KEY_W       = 90;
  localparam int KEY_H       = 65;
  localparam int KEY_GAP     = 20;
  localparam int PANEL_W     = 800;
  localparam int PAD_TOP     = 100;
  localparam int PAD_LEFT    = PANEL_W / 2 - (3 * KEY_W + 2 * KEY_GAP) / 2;
  localparam int LAST_SHIFT  = 15;
  localparam int NUM_ROWS    = 4;
  localparam int NUM_COLS    = 3;

  localparam int COL_LEFT [NUM_COLS] = '{
    PAD_LEFT,
    PAD_LEFT + (KEY_W + KEY_GAP),
    PAD_LEFT + 2 * (KEY_W + KEY_GAP) - LAST_SHIFT
  };

  // The lower rows are pushed down a little further than the regular pitch.
  localparam int ROW_TOP [NUM_ROWS] = '{
    PAD_TOP,
    PAD_TOP + (KEY_H + KEY_GAP) + 10,
    PAD_TOP + 2 * (KEY_H + KEY_GAP) + 25,
    PAD_TOP + 3 * (KEY_H + KEY_GAP) + 40
  };

  // Key codes.
  localparam logic [3:0] KEY_NONE  = 4'd0;
  localparam logic [3:0] KEY_CLEAR = 4'd10;
  localparam logic [3:0] KEY_OK    = 4'd11;

  // Layout: "1 2 3", "4 5 6", "7 8 9", "CLR 0 OK".
  localparam logic [3:0] KEY_MAP [NUM_ROWS][NUM_COLS] = '{
    '{4'd1, 4'd2, 4'd3},
    '{4'd4, 4'd5, 4'd6},
    '{4'd7, 4'd8, 4'd9},
    '{KEY_CLEAR, 4'd0, KEY_OK}
  };

  // Configuration register indexes.
  localparam logic CFG_EXP_DIGITS = 1'b0;
  localparam logic CFG_EXP_LENGTH = 1'b1;

  localparam int PIN_DIGITS = 7;
  localparam int CFG_W      = 4 * PIN_DIGITS;

  // One poll sample of the touch panel.
  typedef struct packed {
    logic       touch_down;
    logic [9:0] touch_x;
    logic [9:0] touch_y;
  } tkpl_in_t;

  // One result per sample.
  typedef struct packed {
    logic       key_hit;
    logic [3:0] key_code;
    logic [2:0] entered_count;
    logic       pin_accepted;
    logic       pin_rejected;
    logic       unlocked;
  } tkpl_res_t;

  // A classified sample passed from the front end to the entry logic.
  typedef struct packed {
    logic       hit;
    logic [3:0] code;
  } tkpl_cmd_t;

  // Configured PIN.
  typedef struct packed {
    logic [CFG_W-1:0] exp_digits;
    logic [2:0]       exp_length;
  } tkpl_cfg_t;

endpackage

`default_nettype wire

// File: hdl/tkpl_fifo.sv
`default_nettype none

module tkpl_fifo import tkpl_pkg::*; #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  T     data_i,
  output logic full_o,
  input  wire  pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CNTW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage is written only on a transfer in.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/tkpl_front.sv
`default_nettype none

module tkpl_front import tkpl_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       accept_i,
  input  tkpl_in_t  item_i,
  output tkpl_cmd_t cmd_o
);

  logic       armed_q;
  logic       press;
  logic       on_key;
  logic [3:0] key;

  // A press counts only on the transition from no touch to touch.
  assign press = item_i.touch_down && !armed_q;

  // Hit test against the twelve key rectangles; they never overlap.
  always_comb begin
    on_key = 1'b0;
    key    = KEY_NONE;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        if (item_i.touch_x >= 10'(COL_LEFT[c]) &&
            item_i.touch_x <= 10'(COL_LEFT[c] + KEY_W) &&
            item_i.touch_y >= 10'(ROW_TOP[r]) &&
            item_i.touch_y <= 10'(ROW_TOP[r] + KEY_H)) begin
          on_key = 1'b1;
          key    = KEY_MAP[r][c];
        end
      end
    end
  end

  assign cmd_o.hit  = press && on_key;
  assign cmd_o.code = (press && on_key) ? key : KEY_NONE;

  // The detector follows the touch flag of every accepted sample: a release
  // re-arms it and a held touch keeps it set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
    end else if (accept_i) begin
      armed_q <= item_i.touch_down;
    end
  end

endmodule

`default_nettype wire

// File: hdl/tkpl_back.sv
`default_nettype none

module tkpl_back import tkpl_pkg::*; #(
  parameter int MAX_DIGITS = 7
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  tkpl_cfg_t cfg_i,
  input  wire       cmd_valid_i,
  input  tkpl_cmd_t cmd_i,
  output logic      cmd_pop_o,
  input  wire       res_ready_i,
  output logic      res_push_o,
  output tkpl_res_t res_o
);

  localparam int CW   = $clog2(MAX_DIGITS + 1);
  localparam int LW   = (CW > 3) ? CW : 3;
  localparam int NCMP = (MAX_DIGITS < PIN_DIGITS) ? MAX_DIGITS : PIN_DIGITS;

  logic [3:0]    digits_q [MAX_DIGITS];
  logic [CW-1:0] count_q, count_d;
  logic          unlocked_q, unlocked_d;
  logic          take;
  logic          active;
  logic          is_digit;
  logic          store;
  logic          match;
  logic          accepted, rejected;
  logic [NCMP-1:0] digit_ok;

  assign take       = cmd_valid_i && res_ready_i;
  assign cmd_pop_o  = take;
  assign res_push_o = take;

  // Once unlocked, every touch is ignored.
  assign active   = cmd_i.hit && !unlocked_q;
  assign is_digit = (cmd_i.code != KEY_CLEAR) && (cmd_i.code != KEY_OK);
  assign store    = take && active && is_digit && (count_q < CW'(MAX_DIGITS));

  // Each held digit must equal its nibble of the configured PIN.
  for (genvar i = 0; i < NCMP; i++) begin : g_cmp
    assign digit_ok[i] = (CW'(i) >= count_q) ||
                         (digits_q[i] == cfg_i.exp_digits[4*i +: 4]);
  end

  assign match = (LW'(count_q) == LW'(cfg_i.exp_length)) && (&digit_ok);

  // Next entry state for the command at the head of the queue.
  always_comb begin
    count_d    = count_q;
    unlocked_d = unlocked_q;
    accepted   = 1'b0;
    rejected   = 1'b0;
    if (active) begin
      unique case (cmd_i.code)
        KEY_CLEAR: begin
          count_d = '0;
        end
        KEY_OK: begin
          if (match) begin
            accepted   = 1'b1;
            unlocked_d = 1'b1;
          end else begin
            rejected = 1'b1;
            count_d  = '0;
          end
        end
        default: begin
          if (count_q < CW'(MAX_DIGITS)) begin
            count_d = count_q + 1'b1;
          end
        end
      endcase
    end
  end

  assign res_o.key_hit       = active;
  assign res_o.key_code      = unlocked_q ? KEY_NONE : cmd_i.code;
  assign res_o.entered_count = 3'(count_d);
  assign res_o.pin_accepted  = accepted;
  assign res_o.pin_rejected  = rejected;
  assign res_o.unlocked      = unlocked_d;

  // Digits are only read below the count, so they need no clearing.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (store && count_q == CW'(i)) begin
        digits_q[i] <= cmd_i.code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      unlocked_q <= 1'b0;
    end else if (take) begin
      count_q    <= count_d;
      unlocked_q <= unlocked_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/touch_keypad_pin_lock.sv
`default_nettype none

// PIN lock fed by touch-panel poll samples. Each sample pushed in gives exactly
// one result, in order. A front end detects new presses and hit-tests them
// against the twelve keys of a 4x3 keypad; a two-entry queue carries the
// classified samples to the entry logic, which appends digits (up to
// MAX_DIGITS), clears, or checks the PIN on OK, and writes its result into a
// two-entry result queue. One sample is taken every clock cycle while neither
// queue is full: the entry update and the PIN compare are combinational, and each
// sample is registered in the command queue and its result in the result queue
// before it appears on the result ports. Either side may stall freely.
// Write the expected PIN only while no sample is in flight.
module touch_keypad_pin_lock import tkpl_pkg::*; #(
  parameter int MAX_DIGITS = 7
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire              cfg_idx_i,
  input  wire  [CFG_W-1:0] cfg_wdata_i,
  input  wire              push,
  input  tkpl_in_t         in_item_i,
  output logic             full,
  input  wire              pop,
  output tkpl_res_t        res_item_o,
  output logic             empty
);

  tkpl_cfg_t cfg_q;
  tkpl_cmd_t front_cmd, head_cmd;
  tkpl_res_t back_res;
  logic      in_accept;
  logic      cmd_empty, cmd_pop;
  logic      res_full, res_push;

  assign in_accept = push && !full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.exp_digits <= '0;
      cfg_q.exp_length <= 3'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EXP_DIGITS: cfg_q.exp_digits <= cfg_wdata_i;
        CFG_EXP_LENGTH: cfg_q.exp_length <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  tkpl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_item_i),
    .cmd_o    (front_cmd)
  );

  tkpl_fifo #(
    .T     (tkpl_cmd_t),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (head_cmd),
    .empty_o (cmd_empty)
  );

  tkpl_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_ready_i (!res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  tkpl_fifo #(
    .T     (tkpl_res_t),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_item_o),
    .empty_o (empty)
  );

`ifndef SYNTH
  // A classified command never carries a key code without a hit.
  a_code_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !front_cmd.hit |-> front_cmd.code == KEY_NONE)
    else $error("key code without a key hit");

  // Accept and reject are exclusive, and an accept always comes with unlock.
  a_pulses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !(back_res.pin_accepted && back_res.pin_rejected) &&
                 (!back_res.pin_accepted || back_res.unlocked))
    else $error("inconsistent accept and reject pulses");

  // Once unlocked, no touch is reported as a key hit.
  a_locked_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && res_item_o.unlocked && !res_item_o.pin_accepted |->
      !res_item_o.key_hit && !res_item_o.pin_rejected)
    else $error("key activity after unlock");

  // The unlock is sticky across consecutive results.
  a_sticky_unlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && res_item_o.unlocked |=> empty || res_item_o.unlocked)
    else $error("unlock flag dropped");
`endif

endmodule

`default_nettype wire
